FILE: rtl/esc_pkg.sv
// Package for the epoch-seconds to calendar converter.
// Holds the sequencer and divider stage types, calendar constants and table functions.
// No dependencies.
`default_nettype none

package esc_pkg;

   // Calendar constants.
   localparam logic [11:0] BASE_YEAR      = 12'd1970;
   localparam logic [6:0]  BASE_YEAR_M100 = 7'd70;
   localparam logic [8:0]  BASE_YEAR_M400 = 9'd370;
   localparam logic [6:0]  LAST_M100      = 7'd99;
   localparam logic [8:0]  LAST_M400      = 9'd399;
   localparam logic [8:0]  DAYS_LEAP      = 9'd366;
   localparam logic [8:0]  DAYS_COMMON    = 9'd365;
   localparam logic [3:0]  MONTHS         = 4'd12;
   localparam logic [4:0]  DIV_LAST_BIT   = 5'd31;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_YEAR,
      ST_MONTH,
      ST_DONE
   } state_type;

   // Which quotient the serial divider is producing.
   typedef enum logic [1:0] {
      DIV_SEC,
      DIV_MIN,
      DIV_HOUR
   } div_stage_type;

   // Divisor for each divider pass.
   function automatic logic [6:0] stage_divisor(input div_stage_type stage);
      logic [6:0] d;
      unique case (stage)
         DIV_SEC:  d = 7'd60;
         DIV_MIN:  d = 7'd60;
         DIV_HOUR: d = 7'd24;
         default:  d = 7'd60;
      endcase
      return d;
   endfunction

   // Length of a month (zero-based index), with a 29-day February in leap years.
   function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd1:    len = leap ? 5'd29 : 5'd28;
         4'd3,
         4'd5,
         4'd8,
         4'd10:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/epoch_seconds_to_calendar.sv
// Epoch-seconds to Gregorian calendar converter, top level.
// Depends on esc_pkg for state types, constants and the month table.
`default_nettype none

// Usage:
// An item enters on req_epoch_seconds (unsigned seconds since 1970-01-01
// 00:00:00 UTC) when req_valid and req_ready are both high. The calendar
// time leaves on the rsp_ ports when rsp_valid and rsp_ready are both high.
// One item is worked on at a time; req_ready is high only while the
// sequencer is idle.
// A bit-serial restoring divider makes three passes (by 60, 60 and 24).
// The year loop then strips one elapsed year per cycle, the month loop
// one elapsed month per cycle, and the result is then loaded into the
// output register. The sequencer is idle again right after the load, so
// a new item is accepted only once the previous one has been loaded.
// The result sits in an output register, so a new item is accepted as soon
// as the sequencer is idle even while the previous result waits. If the
// receiver stalls and the output register is still full when the next
// result is ready, the sequencer holds that result until the register frees.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// rsp_valid.

module epoch_seconds_to_calendar (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_epoch_seconds,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [5:0]       rsp_second_of_minute,
   output logic [5:0]       rsp_minute_of_hour,
   output logic [4:0]       rsp_hour_of_day,
   output logic [4:0]       rsp_day_of_month,
   output logic [3:0]       rsp_month_number,
   output logic [11:0]      rsp_year_number
);

   // Control registers.
   esc_pkg::state_type     state_ff, state_in;
   esc_pkg::div_stage_type stage_ff, stage_in;
   logic [4:0]             bit_cnt_ff, bit_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Working registers.
   logic [31:0] num_ff, num_in;
   logic [5:0]  rem_ff, rem_in;
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hour_ff, hour_in;
   logic [15:0] days_ff, days_in;
   logic [11:0] year_ff, year_in;
   logic [6:0]  m100_ff, m100_in;
   logic [8:0]  m400_ff, m400_in;
   logic [3:0]  month_ff, month_in;

   // Output registers.
   logic [5:0]  out_sec_ff, out_sec_in;
   logic [5:0]  out_min_ff, out_min_in;
   logic [4:0]  out_hour_ff, out_hour_in;
   logic [4:0]  out_day_ff, out_day_in;
   logic [3:0]  out_month_ff, out_month_in;
   logic [11:0] out_year_ff, out_year_in;

   // Divider step signals.
   logic [6:0]  rem_shift;
   logic [6:0]  divisor;
   logic        q_bit;
   logic [6:0]  rem_diff;
   logic [5:0]  rem_next;
   logic [31:0] num_next;

   // Calendar signals.
   logic        leap;
   logic [8:0]  year_len;
   logic [4:0]  month_len;
   logic        out_free;

   // Control state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= esc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers; no reset needed.
   always_ff @(posedge clock) begin
      stage_ff     <= stage_in;
      bit_cnt_ff   <= bit_cnt_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      sec_ff       <= sec_in;
      min_ff       <= min_in;
      hour_ff      <= hour_in;
      days_ff      <= days_in;
      year_ff      <= year_in;
      m100_ff      <= m100_in;
      m400_ff      <= m400_in;
      month_ff     <= month_in;
      out_sec_ff   <= out_sec_in;
      out_min_ff   <= out_min_in;
      out_hour_ff  <= out_hour_in;
      out_day_ff   <= out_day_in;
      out_month_ff <= out_month_in;
      out_year_ff  <= out_year_in;
   end

   // One restoring-division step: bring down one dividend bit per cycle.
   always_comb begin
      rem_shift = {rem_ff, num_ff[31]};
      divisor   = esc_pkg::stage_divisor(stage_ff);
      q_bit     = (rem_shift >= divisor);
      rem_diff  = rem_shift - divisor;
      rem_next  = q_bit ? rem_diff[5:0] : rem_shift[5:0];
      num_next  = {num_ff[30:0], q_bit};
   end

   // Gregorian leap rule from the year's low bits and its residues mod 100 and 400.
   always_comb begin
      leap      = (year_ff[1:0] == 2'b00) && ((m100_ff != 7'd0) || (m400_ff == 9'd0));
      year_len  = leap ? esc_pkg::DAYS_LEAP : esc_pkg::DAYS_COMMON;
      month_len = esc_pkg::month_length(month_ff, leap);
      out_free  = !rsp_valid_ff || rsp_ready;
   end

   // Next state and datapath updates.
   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      bit_cnt_in   = bit_cnt_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      sec_in       = sec_ff;
      min_in       = min_ff;
      hour_in      = hour_ff;
      days_in      = days_ff;
      year_in      = year_ff;
      m100_in      = m100_ff;
      m400_in      = m400_ff;
      month_in     = month_ff;
      out_sec_in   = out_sec_ff;
      out_min_in   = out_min_ff;
      out_hour_in  = out_hour_ff;
      out_day_in   = out_day_ff;
      out_month_in = out_month_ff;
      out_year_in  = out_year_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;

      unique case (state_ff)
         // Wait for an item and load the dividend.
         esc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               num_in     = req_epoch_seconds;
               rem_in     = 6'd0;
               bit_cnt_in = 5'd0;
               stage_in   = esc_pkg::DIV_SEC;
               state_in   = esc_pkg::ST_DIV;
            end
         end

         // Serial divider: three passes give seconds, minutes, hours and days.
         esc_pkg::ST_DIV: begin
            num_in     = num_next;
            rem_in     = rem_next;
            bit_cnt_in = bit_cnt_ff + 5'd1;
            if (bit_cnt_ff == esc_pkg::DIV_LAST_BIT) begin
               rem_in = 6'd0;
               case (stage_ff)
                  esc_pkg::DIV_SEC: begin
                     sec_in   = rem_next;
                     stage_in = esc_pkg::DIV_MIN;
                  end
                  esc_pkg::DIV_MIN: begin
                     min_in   = rem_next;
                     stage_in = esc_pkg::DIV_HOUR;
                  end
                  default: begin
                     hour_in  = rem_next[4:0];
                     days_in  = num_next[15:0];
                     year_in  = esc_pkg::BASE_YEAR;
                     m100_in  = esc_pkg::BASE_YEAR_M100;
                     m400_in  = esc_pkg::BASE_YEAR_M400;
                     state_in = esc_pkg::ST_YEAR;
                  end
               endcase
            end
         end

         // Strip whole years, one per cycle.
         esc_pkg::ST_YEAR: begin
            if (days_ff >= {7'd0, year_len}) begin
               days_in = days_ff - {7'd0, year_len};
               year_in = year_ff + 12'd1;
               m100_in = (m100_ff == esc_pkg::LAST_M100) ? 7'd0 : m100_ff + 7'd1;
               m400_in = (m400_ff == esc_pkg::LAST_M400) ? 9'd0 : m400_ff + 9'd1;
            end else begin
               month_in = 4'd0;
               state_in = esc_pkg::ST_MONTH;
            end
         end

         // Strip whole months, one per cycle.
         esc_pkg::ST_MONTH: begin
            if ((month_ff < esc_pkg::MONTHS) && (days_ff >= {11'd0, month_len})) begin
               days_in  = days_ff - {11'd0, month_len};
               month_in = month_ff + 4'd1;
            end else begin
               state_in = esc_pkg::ST_DONE;
            end
         end

         // Hand the result to the output register once it is free.
         esc_pkg::ST_DONE: begin
            if (out_free) begin
               out_sec_in   = sec_ff;
               out_min_in   = min_ff;
               out_hour_in  = hour_ff;
               out_day_in   = days_ff[4:0] + 5'd1;
               out_month_in = month_ff + 4'd1;
               out_year_in  = year_ff;
               rsp_valid_in = 1'b1;
               state_in     = esc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = esc_pkg::ST_IDLE;
         end
      endcase
   end

   // Result ports.
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_second_of_minute = out_sec_ff;
   assign rsp_minute_of_hour   = out_min_ff;
   assign rsp_hour_of_day      = out_hour_ff;
   assign rsp_day_of_month     = out_day_ff;
   assign rsp_month_number     = out_month_ff;
   assign rsp_year_number      = out_year_ff;

endmodule

`default_nettype wire
